### rtl/hmm_viterbi_decoder_defines.svh
// Assertion macros for the decoder checker
`ifndef HMM_VITERBI_DECODER_DEFINES_SVH
`define HMM_VITERBI_DECODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define HVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hvd_pkg.sv
// Types, constants and helpers for the HMM Viterbi decoder
package hvd_pkg;

  localparam int NUM_STATES_DEF = 4;
  localparam int StateW = 4;
  localparam int LogW = 20;
  localparam int MetW = 32;

  localparam logic signed [LogW-1:0] LOG_NEG_INF = {1'b1, {(LogW-1){1'b0}}};
  localparam logic signed [MetW-1:0] MET_MIN = {1'b1, {(MetW-1){1'b0}}};
  localparam logic signed [MetW-1:0] MET_MAX = {1'b0, {(MetW-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_INIT  = 2'd1,
    OP_START      = 2'd2,
    OP_OBSERVE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SWEEP,
    ST_EMIT,
    ST_REPORT,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t                     opcode;
    logic [StateW-1:0]       from_state;
    logic [StateW-1:0]       to_state;
    logic signed [LogW-1:0]  log_value;
  } req_t;

  typedef struct packed {
    logic [StateW-1:0]       best_state;
    logic signed [MetW-1:0]  best_metric;
  } rsp_t;

  typedef struct packed {
    logic              clr;
    logic              step;
    logic [StateW-1:0] idx;
  } acs_ctrl_t;

  // widen a log value, zero probability becoming the metric floor
  function automatic logic signed [MetW-1:0] lift(input logic signed [LogW-1:0] v);
    lift = (v == LOG_NEG_INF) ? MET_MIN : MetW'(v);
  endfunction

endpackage

### rtl/hvd_ram.sv
// Generic single-write, single-read RAM with registered read data
module hvd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/hvd_acs.sv
// Shared saturating add and compare unit with running maximum
module hvd_acs import hvd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  acs_ctrl_t              ctrl,
  input  logic signed [MetW-1:0] a,
  input  logic signed [MetW-1:0] b,
  output logic signed [MetW-1:0] sum,
  output logic signed [MetW-1:0] best_metric,
  output logic [StateW-1:0]      best_index
);

  logic signed [MetW:0] wide;

  assign wide = {a[MetW-1], a} + {b[MetW-1], b};

  always_comb begin
    if (a == MET_MIN || b == MET_MIN) begin
      sum = MET_MIN;
    end else if (wide[MetW] != wide[MetW-1]) begin
      sum = wide[MetW] ? MET_MIN : MET_MAX;
    end else begin
      sum = wide[MetW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      best_metric <= MET_MIN;
      best_index  <= '0;
    end else if (ctrl.step && (sum > best_metric)) begin
      best_metric <= sum;
      best_index  <= ctrl.idx;
    end
  end

endmodule

### rtl/hmm_viterbi_decoder.sv
// Top level of the log-domain HMM Viterbi decoder
// A load word writes its table entry while the decoder stays idle. A start
// word streams the log-initial table through the shared add/compare unit,
// one state a cycle, each taken from the registered RAM read, then the result is
// offered. An observe word does one add/compare per previous state plus the
// emission add; the observe that closes a time step then scans the new
// metrics for the best state and offers the result. The input is not ready
// while a word is in work; a pending result is held in its own register and
// does not stop the next word being taken.
module hmm_viterbi_decoder import hvd_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SW  = $clog2(NUM_STATES);
  localparam int KW  = $clog2(NUM_STATES + 1);
  localparam int TAW = $clog2(NUM_STATES * NUM_STATES);

  st_t state, state_next;
  logic [KW-1:0] k;
  logic [KW-1:0] km1;
  logic [SW-1:0] cur;
  logic signed [LogW-1:0] emis;
  logic signed [MetW-1:0] metric_prev [NUM_STATES];
  logic signed [MetW-1:0] metric_next [NUM_STATES];

  acs_ctrl_t ctrl;
  logic signed [MetW-1:0] a_op, b_op, sum, acc_metric;
  logic [StateW-1:0] acc_index;

  logic accept, last_state;
  logic trans_we, init_we;
  logic [TAW-1:0] trans_waddr, trans_raddr;
  logic [SW-1:0] init_raddr;
  logic [LogW-1:0] trans_rdata, init_rdata;

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign km1        = k - 1'b1;
  assign last_state = (cur == SW'(NUM_STATES - 1));

  assign trans_we = accept && (req.opcode == OP_LOAD_TRANS)
                    && ({1'b0, req.from_state} < (StateW+1)'(NUM_STATES))
                    && ({1'b0, req.to_state} < (StateW+1)'(NUM_STATES));
  assign init_we  = accept && (req.opcode == OP_LOAD_INIT)
                    && ({1'b0, req.to_state} < (StateW+1)'(NUM_STATES));
  assign trans_waddr = TAW'(req.from_state[SW-1:0] * NUM_STATES + req.to_state[SW-1:0]);
  assign trans_raddr = TAW'(k * NUM_STATES + cur);
  assign init_raddr  = k[SW-1:0];

  hvd_ram #(.Width(LogW), .Depth(NUM_STATES * NUM_STATES)) u_trans (
    .clk     (clk),
    .wr_en   (trans_we),
    .wr_addr (trans_waddr),
    .wr_data (req.log_value),
    .rd_addr (trans_raddr),
    .rd_data (trans_rdata)
  );

  hvd_ram #(.Width(LogW), .Depth(NUM_STATES)) u_init (
    .clk     (clk),
    .wr_en   (init_we),
    .wr_addr (req.to_state[SW-1:0]),
    .wr_data (req.log_value),
    .rd_addr (init_raddr),
    .rd_data (init_rdata)
  );

  hvd_acs u_acs (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .a           (a_op),
    .b           (b_op),
    .sum         (sum),
    .best_metric (acc_metric),
    .best_index  (acc_index)
  );

  always_comb begin
    state_next = state;
    ctrl       = '0;
    a_op       = acc_metric;
    b_op       = '0;
    case (state)
      ST_IDLE: begin
        if (accept && req.opcode == OP_START) begin
          ctrl.clr   = 1'b1;
          state_next = ST_INIT;
        end else if (accept && req.opcode == OP_OBSERVE) begin
          ctrl.clr   = 1'b1;
          state_next = ST_SWEEP;
        end
      end
      ST_INIT: begin
        a_op      = lift(init_rdata);
        ctrl.step = (k != '0);
        ctrl.idx  = StateW'(km1[SW-1:0]);
        if (k == KW'(NUM_STATES)) begin
          state_next = ST_OUT;
        end
      end
      ST_SWEEP: begin
        a_op      = metric_prev[km1[SW-1:0]];
        b_op      = lift(trans_rdata);
        ctrl.step = (k != '0);
        ctrl.idx  = StateW'(km1[SW-1:0]);
        if (k == KW'(NUM_STATES)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        b_op = lift(emis);
        if (last_state) begin
          ctrl.clr   = 1'b1;
          state_next = ST_REPORT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        a_op      = metric_prev[k[SW-1:0]];
        ctrl.step = 1'b1;
        ctrl.idx  = StateW'(k[SW-1:0]);
        if (k == KW'(NUM_STATES - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      cur       <= '0;
      rsp_valid <= 1'b0;
      for (int x = 0; x < NUM_STATES; x++) begin
        metric_prev[x] <= '0;
        metric_next[x] <= '0;
      end
    end else begin
      state <= state_next;
      if (state_next != state || state == ST_IDLE || state == ST_OUT) begin
        k <= '0;
      end else begin
        k <= k + 1'b1;
      end
      if (state == ST_OUT && state_next == ST_IDLE) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept && req.opcode == OP_START) begin
        cur <= '0;
      end
      if (state == ST_INIT && k != '0) begin
        metric_prev[km1[SW-1:0]] <= sum;
      end
      if (state == ST_EMIT) begin
        metric_next[cur] <= sum;
        if (last_state) begin
          cur <= '0;
          for (int x = 0; x < NUM_STATES; x++) begin
            metric_prev[x] <= (SW'(x) == cur) ? sum : metric_next[x];
          end
        end else begin
          cur <= cur + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emis <= req.log_value;
    end
    if (state == ST_OUT && state_next == ST_IDLE) begin
      rsp.best_state  <= acc_index;
      rsp.best_metric <= acc_metric;
    end
  end

endmodule

### rtl/hvd_checker.sv
// Port-level checker for the HMM Viterbi decoder, bound to the top level
`include "hmm_viterbi_decoder_defines.svh"

module hvd_checker import hvd_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `HVD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result word dropped or changed while stalled")
  `HVD_ASSERT_NEXT(a_busy_after_work, req_valid && req_ready && req.opcode[1], !req_ready, "ready held after start or observe word")
  `HVD_ASSERT_NEXT(a_load_silent, req_valid && req_ready && !req.opcode[1] && !rsp_valid, !rsp_valid, "load word produced a result")
  `HVD_ASSERT_NOW(a_state_range, rsp_valid, {1'b0, rsp.best_state} < (StateW+1)'(NUM_STATES), "best state out of range")
  `HVD_ASSERT_NOW(a_reset_quiet, $past(rst), !rsp_valid, "result valid straight after reset")

endmodule

bind hmm_viterbi_decoder hvd_checker #(.NUM_STATES(NUM_STATES)) u_hvd_checker (.*);
